FILE: sv/apsta_pkg.sv
// Shared types and codes for the access-point station association table.
// Request and result payload structs, event/reply codes and station states.
// No dependencies.
package apsta_pkg;

	localparam int ADDR_W    = 48;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FOUR_STEP_AUTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LAYER    = 2'd1;

	// Event codes
	localparam logic [3:0] ACT_AUTH     = 4'd0;
	localparam logic [3:0] ACT_DEAUTH   = 4'd1;
	localparam logic [3:0] ACT_ASSOC    = 4'd2;
	localparam logic [3:0] ACT_REASSOC  = 4'd3;
	localparam logic [3:0] ACT_DISASSOC = 4'd4;
	localparam logic [3:0] ACT_PROBE    = 4'd5;
	localparam logic [3:0] ACT_DOWNLINK = 4'd6;
	localparam logic [3:0] ACT_UPLINK   = 4'd7;
	localparam logic [3:0] ACT_BEACON   = 4'd8;
	localparam logic [3:0] ACT_CLEAR    = 4'd9;

	// Reply kinds
	localparam logic [2:0] RPL_NONE    = 3'd0;
	localparam logic [2:0] RPL_AUTH    = 3'd1;
	localparam logic [2:0] RPL_DEAUTH  = 3'd2;
	localparam logic [2:0] RPL_ASSOC   = 3'd3;
	localparam logic [2:0] RPL_REASSOC = 3'd4;
	localparam logic [2:0] RPL_PROBE   = 3'd5;
	localparam logic [2:0] RPL_BEACON  = 3'd6;

	// Reply status
	localparam logic [1:0] STS_SUCCESS  = 2'd0;
	localparam logic [1:0] STS_OUT_SEQ  = 2'd1;
	localparam logic [1:0] STS_NOT_AUTH = 2'd2;

	// Data actions
	localparam logic [2:0] DATA_DROP       = 3'd0;
	localparam logic [2:0] DATA_WIRELESS   = 3'd1;
	localparam logic [2:0] DATA_UPPER      = 3'd2;
	localparam logic [2:0] DATA_DISTRIBUTE = 3'd3;
	localparam logic [2:0] DATA_UPPER_DIST = 3'd4;

	// Notifications
	localparam logic [1:0] NTF_NONE     = 2'd0;
	localparam logic [1:0] NTF_ASSOC    = 2'd1;
	localparam logic [1:0] NTF_DISASSOC = 2'd2;

	localparam int MCAST_BIT = 40;

	typedef enum logic [1:0] {
		STA_NONE  = 2'd0,
		STA_AUTH  = 2'd1,
		STA_ASSOC = 2'd2
	} sta_state_t;

	typedef struct packed {
		sta_state_t  state;
		logic [1:0]  expected_seq;
	} entry_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_SCAN = 2'd1,
		FSM_EXEC = 2'd2
	} fsm_t;

	typedef struct packed {
		logic [3:0]        action;
		logic [ADDR_W-1:0] station_address;
		logic [15:0]       auth_seq;
		logic              to_ds;
		logic              ssid_ok;
	} req_t;

	typedef struct packed {
		logic [2:0]        reply_kind;
		logic [1:0]        reply_status;
		logic [2:0]        reply_seq;
		logic              reply_is_last;
		logic [ADDR_W-1:0] peer_address;
		logic [2:0]        data_action;
		logic [1:0]        notify_kind;
		logic              table_full;
	} res_t;

endpackage

FILE: sv/wlan_ap_station_association_table_top.sv
// Station association table for an access point: address lookup, auth/assoc sequencing.
// Single module; uses apsta_pkg for payload structs, codes and the sequencer states.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------
//   req     | in        | req_valid / req_stall  | apsta_pkg::req_t
//   res     | out       | res_valid / res_stall  | apsta_pkg::res_t
//   cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A request that matches entry k reads entries 0 to k, one that misses reads every entry,
// and probe, beacon, clear and unknown codes skip the scan. The scan is a linear pass over the
// address memory, one entry per cycle through its single read port.
// Reset clears the valid bits at once; no clearing pass is needed.
// A stalled result waits in the output register; the next request is taken meanwhile
// and holds in its last step until the output register is free.
module wlan_ap_station_association_table_top #(
	parameter int MAX_STATIONS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  apsta_pkg::req_t                    req_data,
	output logic                               res_valid,
	input  logic                               res_stall,
	output apsta_pkg::res_t                    res_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [apsta_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic                               cfg_data
);

	localparam int IDX_W = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
	localparam int CNT_W = $clog2(MAX_STATIONS + 1);

	// Table storage
	logic [apsta_pkg::ADDR_W-1:0] addr_mem [MAX_STATIONS];
	apsta_pkg::entry_t            ent_mem  [MAX_STATIONS];
	logic [MAX_STATIONS-1:0]      valid_q;

	// Configuration
	logic four_step_q;
	logic upper_q;

	// Sequencer
	apsta_pkg::fsm_t state_q, state_n;
	apsta_pkg::req_t req_q;
	logic [CNT_W-1:0] scan_cnt_q;
	logic             hit_q;
	logic [IDX_W-1:0] ent_idx_q;
	apsta_pkg::entry_t ent_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	// Scan pipeline
	logic                         cmp_vld_s1;
	logic [IDX_W-1:0]             cmp_idx_s1;
	logic [apsta_pkg::ADDR_W-1:0] rd_addr_s1;
	apsta_pkg::entry_t            rd_ent_s1;

	// Output register
	logic            res_valid_q;
	apsta_pkg::res_t res_q;

	// Control
	logic accept;
	logic scan_issue;
	logic exec_fire;
	logic needs_scan;
	logic cmp_hit;
	logic cmp_last;
	logic scan_done;

	// Decision
	apsta_pkg::res_t   res_n;
	logic              ent_we;
	logic              addr_we;
	logic              clear_all;
	apsta_pkg::entry_t ent_wdata;
	logic [IDX_W-1:0]  wr_idx;

	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_step_q <= 1'b1;
			upper_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == apsta_pkg::CFG_FOUR_STEP_AUTH) begin
				four_step_q <= cfg_data;
			end
			if (cfg_index == apsta_pkg::CFG_UPPER_LAYER) begin
				upper_q <= cfg_data;
			end
		end
	end

	always_comb begin
		unique case (req_data.action)
			apsta_pkg::ACT_AUTH, apsta_pkg::ACT_DEAUTH, apsta_pkg::ACT_ASSOC,
			apsta_pkg::ACT_REASSOC, apsta_pkg::ACT_DISASSOC, apsta_pkg::ACT_DOWNLINK,
			apsta_pkg::ACT_UPLINK: needs_scan = 1'b1;
			default:               needs_scan = 1'b0;
		endcase
	end

	assign cmp_hit  = cmp_vld_s1 && valid_q[cmp_idx_s1] &&
	                  (rd_addr_s1 == req_q.station_address);
	assign cmp_last = cmp_vld_s1 && (cmp_idx_s1 == IDX_W'(MAX_STATIONS - 1));
	assign scan_done = cmp_hit || cmp_last;

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			apsta_pkg::FSM_IDLE: begin
				if (accept) begin
					state_n = needs_scan ? apsta_pkg::FSM_SCAN : apsta_pkg::FSM_EXEC;
				end
			end
			apsta_pkg::FSM_SCAN: begin
				if (scan_done) begin
					state_n = apsta_pkg::FSM_EXEC;
				end
			end
			apsta_pkg::FSM_EXEC: begin
				if (exec_fire) begin
					state_n = apsta_pkg::FSM_IDLE;
				end
			end
			default: state_n = apsta_pkg::FSM_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		req_stall  = (state_q != apsta_pkg::FSM_IDLE);
		accept     = req_valid && (state_q == apsta_pkg::FSM_IDLE);
		scan_issue = (state_q == apsta_pkg::FSM_SCAN) && !scan_done &&
		             (scan_cnt_q != CNT_W'(MAX_STATIONS));
		exec_fire  = (state_q == apsta_pkg::FSM_EXEC) && (!res_valid_q || !res_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= apsta_pkg::FSM_IDLE;
			scan_cnt_q <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			state_q    <= state_n;
			cmp_vld_s1 <= scan_issue;
			if (accept) begin
				scan_cnt_q <= '0;
				hit_q      <= 1'b0;
				free_q     <= 1'b0;
			end else begin
				if (scan_issue) begin
					scan_cnt_q <= scan_cnt_q + CNT_W'(1);
				end
				if ((state_q == apsta_pkg::FSM_SCAN) && cmp_hit) begin
					hit_q <= 1'b1;
				end
				// remember the lowest free slot in case the station is new
				if ((state_q == apsta_pkg::FSM_SCAN) && cmp_vld_s1 &&
				    !valid_q[cmp_idx_s1] && !free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_data;
		end
		if (scan_issue) begin
			cmp_idx_s1 <= scan_cnt_q[IDX_W-1:0];
		end
		if ((state_q == apsta_pkg::FSM_SCAN) && cmp_hit) begin
			ent_idx_q <= cmp_idx_s1;
			ent_q     <= rd_ent_s1;
		end
		if ((state_q == apsta_pkg::FSM_SCAN) && cmp_vld_s1 &&
		    !valid_q[cmp_idx_s1] && !free_q) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

	// Table memories: one read and one write port each
	always_ff @(posedge clk) begin
		if (scan_issue) begin
			rd_addr_s1 <= addr_mem[scan_cnt_q[IDX_W-1:0]];
			rd_ent_s1  <= ent_mem[scan_cnt_q[IDX_W-1:0]];
		end
		if (exec_fire && addr_we) begin
			addr_mem[wr_idx] <= req_q.station_address;
		end
		if (exec_fire && ent_we) begin
			ent_mem[wr_idx] <= ent_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (exec_fire) begin
			if (clear_all) begin
				valid_q <= '0;
			end else if (addr_we) begin
				valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	assign wr_idx = hit_q ? ent_idx_q : free_idx_q;

	// Event decision
	always_comb begin
		logic       mcast;
		logic [2:0] rseq;
		logic       last;
		apsta_pkg::sta_state_t st;
		logic [1:0] exp_seq;

		mcast     = req_q.station_address[apsta_pkg::MCAST_BIT];
		st        = hit_q ? ent_q.state : apsta_pkg::STA_NONE;
		exp_seq   = hit_q ? ent_q.expected_seq : 2'd1;
		rseq      = 3'(req_q.auth_seq[1:0]) + 3'd1;
		last      = 1'b0;
		res_n     = '0;
		ent_we    = 1'b0;
		addr_we   = 1'b0;
		clear_all = 1'b0;

		unique case (req_q.action)
			apsta_pkg::ACT_AUTH: begin
				if (!hit_q && !free_q) begin
					res_n.table_full = 1'b1;
				end else begin
					addr_we            = !hit_q;
					ent_we             = 1'b1;
					res_n.peer_address = req_q.station_address;
					res_n.reply_kind   = apsta_pkg::RPL_AUTH;
					// sequence 1 always restarts the exchange
					if (req_q.auth_seq == 16'd1) begin
						if (st == apsta_pkg::STA_ASSOC) begin
							res_n.notify_kind = apsta_pkg::NTF_DISASSOC;
						end
						st      = apsta_pkg::STA_NONE;
						exp_seq = 2'd1;
					end
					if (req_q.auth_seq != {14'd0, exp_seq}) begin
						res_n.reply_status = apsta_pkg::STS_OUT_SEQ;
						exp_seq            = 2'd1;
					end else begin
						last                = (rseq == (four_step_q ? 3'd4 : 3'd2));
						res_n.reply_seq     = rseq;
						res_n.reply_is_last = last;
						if (last) begin
							if (st == apsta_pkg::STA_ASSOC) begin
								res_n.notify_kind = apsta_pkg::NTF_DISASSOC;
							end
							st = apsta_pkg::STA_AUTH;
						end else begin
							exp_seq = exp_seq + 2'd2;
						end
					end
				end
			end
			apsta_pkg::ACT_DEAUTH: begin
				if (hit_q) begin
					if (st == apsta_pkg::STA_ASSOC) begin
						res_n.notify_kind  = apsta_pkg::NTF_DISASSOC;
						res_n.peer_address = req_q.station_address;
					end
					ent_we  = 1'b1;
					st      = apsta_pkg::STA_NONE;
					exp_seq = 2'd1;
				end
			end
			apsta_pkg::ACT_ASSOC, apsta_pkg::ACT_REASSOC: begin
				res_n.peer_address = req_q.station_address;
				if (!hit_q || (st == apsta_pkg::STA_NONE)) begin
					res_n.reply_kind   = apsta_pkg::RPL_DEAUTH;
					res_n.reply_status = apsta_pkg::STS_NOT_AUTH;
				end else begin
					if ((req_q.action == apsta_pkg::ACT_ASSOC) &&
					    (st != apsta_pkg::STA_ASSOC)) begin
						res_n.notify_kind = apsta_pkg::NTF_ASSOC;
					end
					res_n.reply_kind = (req_q.action == apsta_pkg::ACT_ASSOC) ?
					                   apsta_pkg::RPL_ASSOC : apsta_pkg::RPL_REASSOC;
					ent_we = 1'b1;
					st     = apsta_pkg::STA_ASSOC;
				end
			end
			apsta_pkg::ACT_DISASSOC: begin
				if (hit_q && (st == apsta_pkg::STA_ASSOC)) begin
					res_n.notify_kind  = apsta_pkg::NTF_DISASSOC;
					res_n.peer_address = req_q.station_address;
					ent_we             = 1'b1;
					st                 = apsta_pkg::STA_AUTH;
				end
			end
			apsta_pkg::ACT_PROBE: begin
				if (req_q.ssid_ok) begin
					res_n.reply_kind   = apsta_pkg::RPL_PROBE;
					res_n.peer_address = req_q.station_address;
				end
			end
			apsta_pkg::ACT_DOWNLINK: begin
				if (mcast || (hit_q && (st == apsta_pkg::STA_ASSOC))) begin
					res_n.data_action = apsta_pkg::DATA_WIRELESS;
				end
			end
			apsta_pkg::ACT_UPLINK: begin
				if (req_q.to_ds) begin
					if (mcast) begin
						res_n.data_action = upper_q ? apsta_pkg::DATA_UPPER_DIST :
						                              apsta_pkg::DATA_DISTRIBUTE;
					end else if (!hit_q) begin
						res_n.data_action = upper_q ? apsta_pkg::DATA_UPPER :
						                              apsta_pkg::DATA_DROP;
					end else if (st == apsta_pkg::STA_ASSOC) begin
						res_n.data_action = apsta_pkg::DATA_DISTRIBUTE;
					end
				end
			end
			apsta_pkg::ACT_BEACON: begin
				res_n.reply_kind   = apsta_pkg::RPL_BEACON;
				res_n.peer_address = '1;
			end
			apsta_pkg::ACT_CLEAR: begin
				clear_all = 1'b1;
			end
			default: begin
				res_n = '0;
			end
		endcase

		ent_wdata.state        = st;
		ent_wdata.expected_seq = exp_seq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (exec_fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			res_q <= res_n;
		end
	end

	// A matched entry is still valid when its event is decided
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == apsta_pkg::FSM_EXEC) && hit_q |-> valid_q[ent_idx_q])
		else $error("matched entry is not valid");

	// The recorded free slot stays free until the event is decided
	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == apsta_pkg::FSM_EXEC) && free_q |-> !valid_q[free_idx_q])
		else $error("free slot is occupied");

	// Firing the decision always leaves a result in the output register
	a_exec_loads: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire |=> res_valid && (state_q == apsta_pkg::FSM_IDLE))
		else $error("decision did not produce a result");

	// A dropped event carries nothing but the full flag
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.table_full |->
		(res_data.reply_kind == apsta_pkg::RPL_NONE) &&
		(res_data.notify_kind == apsta_pkg::NTF_NONE) && (res_data.peer_address == '0))
		else $error("table full result carries other fields");

	// The scan never reads past the last entry
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_issue |-> (scan_cnt_q < CNT_W'(MAX_STATIONS)))
		else $error("scan index out of range");

endmodule

FILE: sim/tb_wlan_ap_station_association_table_top.sv
// Self-checking bench for the AP station association table: directed table, then random sessions.
// Predicts verdicts from its own table but for typed rows; depends on apsta_pkg and top module.
`timescale 1ns / 1ps

module tb_wlan_ap_station_association_table_top;
	import apsta_pkg::*;

	localparam int NSTA       = 32;
	localparam int POOL       = 40;
	localparam int STALL_MAX  = 2000;
	localparam int PHASE_SIZE = 250;

	typedef struct {
		req_t rq;
		bit   typed;
		res_t rs;
	} plan_row_t;

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_stall;
	req_t  req_data;
	logic  res_valid;
	logic  res_stall;
	res_t  res_data;
	logic  cfg_valid;
	logic  cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic  cfg_data;

	// own copy of the station table and mode bits
	logic        sta_valid [NSTA];
	logic [47:0] sta_addr  [NSTA];
	sta_state_t  sta_state [NSTA];
	logic [1:0]  sta_next  [NSTA];
	logic        four_step;
	logic        upper_on;

	res_t        verdicts_due [$];
	plan_row_t   plan [$];
	logic [47:0] pool [POOL];
	int          faults;
	int          sent_events;
	int          quiet_cycles;
	int          stall_left;
	bit          calm;

	wlan_ap_station_association_table_top #(.MAX_STATIONS(NSTA)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic res_t station_verdict(input req_t r);
		res_t       o;
		int         e;
		int         i;
		logic       mcast;
		logic [2:0] rs;
		o = '0;
		e = -1;
		mcast = r.station_address[MCAST_BIT];
		for (i = 0; i < NSTA; i++)
			if (e < 0 && sta_valid[i] && sta_addr[i] == r.station_address)
				e = i;
		case (r.action)
			ACT_AUTH: begin
				if (e < 0) begin
					for (i = 0; i < NSTA; i++)
						if (e < 0 && !sta_valid[i])
							e = i;
					if (e < 0) begin
						o.table_full = 1'b1;
						return o;
					end
					sta_valid[e] = 1'b1;
					sta_addr[e]  = r.station_address;
					sta_state[e] = STA_NONE;
					sta_next[e]  = 2'd1;
				end
				o.peer_address = r.station_address;
				o.reply_kind   = RPL_AUTH;
				// sequence 1 always restarts the exchange
				if (r.auth_seq == 16'd1) begin
					if (sta_state[e] == STA_ASSOC)
						o.notify_kind = NTF_DISASSOC;
					sta_state[e] = STA_NONE;
					sta_next[e]  = 2'd1;
				end
				if (r.auth_seq != {14'd0, sta_next[e]}) begin
					o.reply_status = STS_OUT_SEQ;
					sta_next[e]    = 2'd1;
				end else begin
					rs = r.auth_seq[2:0] + 3'd1;
					o.reply_seq = rs;
					if (rs == (four_step ? 3'd4 : 3'd2)) begin
						o.reply_is_last = 1'b1;
						if (sta_state[e] == STA_ASSOC)
							o.notify_kind = NTF_DISASSOC;
						sta_state[e] = STA_AUTH;
					end else begin
						// two-bit wrap is intended
						sta_next[e] = sta_next[e] + 2'd2;
					end
				end
			end
			ACT_DEAUTH: begin
				if (e >= 0) begin
					if (sta_state[e] == STA_ASSOC) begin
						o.notify_kind  = NTF_DISASSOC;
						o.peer_address = r.station_address;
					end
					sta_state[e] = STA_NONE;
					sta_next[e]  = 2'd1;
				end
			end
			ACT_ASSOC, ACT_REASSOC: begin
				o.peer_address = r.station_address;
				if (e < 0 || sta_state[e] == STA_NONE) begin
					o.reply_kind   = RPL_DEAUTH;
					o.reply_status = STS_NOT_AUTH;
				end else begin
					if (r.action == ACT_ASSOC && sta_state[e] != STA_ASSOC)
						o.notify_kind = NTF_ASSOC;
					sta_state[e] = STA_ASSOC;
					o.reply_kind = (r.action == ACT_ASSOC) ? RPL_ASSOC : RPL_REASSOC;
				end
			end
			ACT_DISASSOC: begin
				if (e >= 0 && sta_state[e] == STA_ASSOC) begin
					o.notify_kind  = NTF_DISASSOC;
					o.peer_address = r.station_address;
					sta_state[e]   = STA_AUTH;
				end
			end
			ACT_PROBE: begin
				if (r.ssid_ok) begin
					o.reply_kind   = RPL_PROBE;
					o.peer_address = r.station_address;
				end
			end
			ACT_DOWNLINK: begin
				if (mcast || (e >= 0 && sta_state[e] == STA_ASSOC))
					o.data_action = DATA_WIRELESS;
			end
			ACT_UPLINK: begin
				if (r.to_ds) begin
					if (mcast)
						o.data_action = upper_on ? DATA_UPPER_DIST : DATA_DISTRIBUTE;
					else if (e < 0)
						o.data_action = upper_on ? DATA_UPPER : DATA_DROP;
					else if (sta_state[e] == STA_ASSOC)
						o.data_action = DATA_DISTRIBUTE;
				end
			end
			ACT_BEACON: begin
				o.reply_kind   = RPL_BEACON;
				o.peer_address = '1;
			end
			ACT_CLEAR: begin
				for (i = 0; i < NSTA; i++)
					sta_valid[i] = 1'b0;
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	function automatic req_t mk_req(input logic [3:0] act, input logic [47:0] a,
		input logic [15:0] seq, input logic tods, input logic ssid);
		req_t r;
		r.action          = act;
		r.station_address = a;
		r.auth_seq        = seq;
		r.to_ds           = tods;
		r.ssid_ok         = ssid;
		return r;
	endfunction

	// random side fields; callers override what matters
	function automatic req_t rnd_req(input logic [3:0] act, input logic [47:0] a);
		return mk_req(act, a, 16'($urandom), 1'($urandom), 1'($urandom));
	endfunction

	function automatic res_t mk_res(input logic [2:0] kind, input logic [1:0] status,
		input logic [2:0] seq, input logic last, input logic [47:0] peer,
		input logic [2:0] data, input logic [1:0] ntf);
		res_t o;
		o.reply_kind    = kind;
		o.reply_status  = status;
		o.reply_seq     = seq;
		o.reply_is_last = last;
		o.peer_address  = peer;
		o.data_action   = data;
		o.notify_kind   = ntf;
		o.table_full    = 1'b0;
		return o;
	endfunction

	task automatic add_row(input req_t r, input bit typed, input res_t o);
		plan_row_t row;
		row.rq    = r;
		row.typed = typed;
		row.rs    = o;
		plan.push_back(row);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// called at a clock edge; returns at the edge where the request is taken
	task automatic issue(input req_t r, input bit typed, input res_t typed_res);
		res_t p;
		int   gap;
		p = station_verdict(r);
		verdicts_due.push_back(typed ? typed_res : p);
		sent_events++;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic send(input req_t r);
		issue(r, 1'b0, '0);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mode(input logic four, input logic upper);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_FOUR_STEP_AUTH;
		cfg_data  <= four;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= CFG_UPPER_LAYER;
		cfg_data  <= upper;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		four_step = four;
		upper_on  = upper;
	endtask

	// mostly well-formed join: auth exchange, association, a little traffic, then maybe a way out
	task automatic run_session();
		logic [47:0] a;
		req_t        r;
		int          n;
		a = pool[$urandom_range(0, POOL - 1)];
		r = rnd_req(ACT_AUTH, a);
		r.auth_seq = 16'd1;
		send(r);
		if ($urandom_range(0, 9) == 0) begin
			r.auth_seq = 16'($urandom_range(0, 4));
			send(r);
		end
		if (four_step) begin
			r.auth_seq = 16'd3;
			send(r);
		end
		send(rnd_req(($urandom_range(0, 3) == 0) ? ACT_REASSOC : ACT_ASSOC, a));
		n = $urandom_range(0, 3);
		repeat (n) begin
			if ($urandom_range(0, 1) == 0) begin
				send(rnd_req(ACT_DOWNLINK, a));
			end else begin
				r = rnd_req(ACT_UPLINK, a);
				r.to_ds = ($urandom_range(0, 4) != 0);
				send(r);
			end
		end
		case ($urandom_range(0, 3))
			0: send(rnd_req(ACT_DISASSOC, a));
			1: send(rnd_req(ACT_DEAUTH, a));
			2: begin
				r = rnd_req(ACT_AUTH, a);
				r.auth_seq = 16'd1;
				send(r);
			end
			default: begin
			end
		endcase
	endtask

	task automatic run_noise();
		req_t r;
		int   k;
		k = $urandom_range(0, 19);
		if (k == 0)
			r = rnd_req(4'($urandom_range(10, 15)), 48'({$urandom, $urandom}));
		else if (k < 4)
			r = rnd_req(4'($urandom_range(0, 8)), 48'({$urandom, $urandom}));
		else
			r = rnd_req(4'($urandom_range(0, 8)), pool[$urandom_range(0, POOL - 1)]);
		if ($urandom_range(0, 1) == 0)
			r.auth_seq = 16'($urandom_range(0, 4));
		send(r);
	endtask

	// result side: check what is taken, then choose the stall for the next edge
	always @(posedge clk) begin
		res_t want;
		int   r;
		int   pick;
		if (arst_n && res_valid && !res_stall) begin
			if (verdicts_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%0t: unexpected result %p", $realtime, res_data);
			end else begin
				want = verdicts_due.pop_front();
				if (res_data !== want) begin
					faults++;
					if (faults <= 10)
						$display("%0t: mismatch exp kind=%0d st=%0d seq=%0d last=%0d",
							$realtime, want.reply_kind, want.reply_status,
							want.reply_seq, want.reply_is_last,
							" peer=%h data=%0d ntf=%0d full=%0d | got kind=%0d st=%0d",
							want.peer_address, want.data_action, want.notify_kind,
							want.table_full, res_data.reply_kind, res_data.reply_status,
							" seq=%0d last=%0d peer=%h data=%0d ntf=%0d full=%0d",
							res_data.reply_seq, res_data.reply_is_last,
							res_data.peer_address, res_data.data_action,
							res_data.notify_kind, res_data.table_full);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (calm || r < 65)
				pick = 0;
			else if (r < 92)
				pick = $urandom_range(1, 3);
			else
				pick = $urandom_range(8, 40);
			res_stall <= (pick > 0);
			stall_left = (pick > 0) ? pick - 1 : 0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (res_valid && !res_stall)
				|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_MAX) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [47:0] sta_c;
		logic [47:0] sta_m;
		req_t        r;
		int          i;
		int          ph;
		int          goal;
		logic        f;
		logic        u;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req_data     = '0;
		res_stall    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = 1'b0;
		faults       = 0;
		sent_events  = 0;
		quiet_cycles = 0;
		stall_left   = 0;
		calm         = 1'b0;
		four_step    = 1'b1;
		upper_on     = 1'b0;
		for (i = 0; i < NSTA; i++) begin
			sta_valid[i] = 1'b0;
			sta_addr[i]  = '0;
			sta_state[i] = STA_NONE;
			sta_next[i]  = 2'd0;
		end
		// more stations than slots, a few of them group addresses
		for (i = 0; i < POOL; i++) begin
			pool[i] = 48'({$urandom, $urandom});
			pool[i][MCAST_BIT] = (i % 8 == 7);
		end
		sta_c = 48'h02AB_CDEF_0123;
		sta_m = 48'h0100_0000_0001;

		add_row(mk_req(ACT_BEACON, sta_c, 16'd0, 1'b0, 1'b0), 1'b1,
			mk_res(RPL_BEACON, STS_SUCCESS, 3'd0, 1'b0, '1, DATA_DROP, NTF_NONE));
		add_row(mk_req(ACT_PROBE, sta_c, 16'd0, 1'b0, 1'b1), 1'b1,
			mk_res(RPL_PROBE, STS_SUCCESS, 3'd0, 1'b0, sta_c, DATA_DROP, NTF_NONE));
		add_row(mk_req(ACT_PROBE, sta_c, 16'd0, 1'b0, 1'b0), 1'b1, '0);
		add_row(mk_req(ACT_ASSOC, sta_c, 16'd0, 1'b0, 1'b0), 1'b1,
			mk_res(RPL_DEAUTH, STS_NOT_AUTH, 3'd0, 1'b0, sta_c, DATA_DROP, NTF_NONE));
		add_row(mk_req(ACT_DEAUTH, sta_c, 16'd0, 1'b0, 1'b0), 1'b1, '0);
		add_row(mk_req(ACT_DISASSOC, sta_c, 16'd0, 1'b0, 1'b0), 1'b1, '0);
		add_row(mk_req(ACT_DOWNLINK, sta_c, 16'd0, 1'b0, 1'b0), 1'b1, '0);
		add_row(mk_req(ACT_DOWNLINK, sta_m, 16'd0, 1'b0, 1'b0), 1'b1,
			mk_res(RPL_NONE, STS_SUCCESS, 3'd0, 1'b0, '0, DATA_WIRELESS, NTF_NONE));
		add_row(mk_req(ACT_UPLINK, sta_m, 16'd0, 1'b0, 1'b0), 1'b1, '0);
		add_row(mk_req(ACT_UPLINK, sta_m, 16'd0, 1'b1, 1'b0), 1'b1,
			mk_res(RPL_NONE, STS_SUCCESS, 3'd0, 1'b0, '0, DATA_DISTRIBUTE, NTF_NONE));
		add_row(mk_req(ACT_UPLINK, sta_c, 16'd0, 1'b1, 1'b0), 1'b1, '0);
		add_row(mk_req(ACT_AUTH, sta_c, 16'd1, 1'b0, 1'b0), 1'b1,
			mk_res(RPL_AUTH, STS_SUCCESS, 3'd2, 1'b0, sta_c, DATA_DROP, NTF_NONE));
		add_row(mk_req(ACT_AUTH, sta_c, 16'd2, 1'b0, 1'b0), 1'b1,
			mk_res(RPL_AUTH, STS_OUT_SEQ, 3'd0, 1'b0, sta_c, DATA_DROP, NTF_NONE));
		add_row(mk_req(ACT_AUTH, sta_c, 16'd1, 1'b1, 1'b1), 1'b0, '0);
		add_row(mk_req(ACT_AUTH, sta_c, 16'd3, 1'b0, 1'b0), 1'b1,
			mk_res(RPL_AUTH, STS_SUCCESS, 3'd4, 1'b1, sta_c, DATA_DROP, NTF_NONE));
		add_row(mk_req(ACT_ASSOC, sta_c, 16'd0, 1'b0, 1'b0), 1'b1,
			mk_res(RPL_ASSOC, STS_SUCCESS, 3'd0, 1'b0, sta_c, DATA_DROP, NTF_ASSOC));
		add_row(mk_req(ACT_REASSOC, sta_c, 16'd0, 1'b0, 1'b0), 1'b1,
			mk_res(RPL_REASSOC, STS_SUCCESS, 3'd0, 1'b0, sta_c, DATA_DROP, NTF_NONE));
		add_row(mk_req(ACT_UPLINK, sta_c, 16'd0, 1'b1, 1'b0), 1'b0, '0);
		add_row(mk_req(ACT_DOWNLINK, sta_c, 16'd0, 1'b0, 1'b0), 1'b0, '0);
		add_row(mk_req(ACT_DISASSOC, sta_c, 16'd0, 1'b0, 1'b0), 1'b1,
			mk_res(RPL_NONE, STS_SUCCESS, 3'd0, 1'b0, sta_c, DATA_DROP, NTF_DISASSOC));
		add_row(mk_req(ACT_DISASSOC, sta_c, 16'd0, 1'b0, 1'b0), 1'b0, '0);
		add_row(mk_req(ACT_AUTH, '0, 16'hFFFF, 1'b0, 1'b0), 1'b1,
			mk_res(RPL_AUTH, STS_OUT_SEQ, 3'd0, 1'b0, '0, DATA_DROP, NTF_NONE));
		add_row(mk_req(4'hF, '1, 16'hFFFF, 1'b1, 1'b1), 1'b1, '0);
		add_row(mk_req(ACT_CLEAR, '1, 16'hFFFF, 1'b1, 1'b1), 1'b1, '0);
		add_row(mk_req(ACT_AUTH, sta_c, 16'd1, 1'b0, 1'b0), 1'b0, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k])
			issue(plan[k].rq, plan[k].typed, plan[k].rs);
		drain();

		for (ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin f = 1'b0; u = 1'b0; end
				1: begin f = 1'b1; u = 1'b1; end
				2: begin f = 1'b0; u = 1'b1; end
				3: begin f = 1'b1; u = 1'b0; end
				default: begin f = 1'($urandom); u = 1'($urandom); end
			endcase
			set_mode(f, u);
			calm = ($urandom_range(0, 3) == 0);
			// mid-exchange switch to two frames: expected number wraps past 3
			if (ph == 0) begin
				r = mk_req(ACT_AUTH, sta_c, 16'd3, 1'b0, 1'b0);
				send(r);
			end
			goal = sent_events + PHASE_SIZE;
			while (sent_events < goal) begin
				i = $urandom_range(0, 199);
				if (i == 0)
					send(rnd_req(ACT_CLEAR, 48'({$urandom, $urandom})));
				else if (i < 140)
					run_session();
				else
					run_noise();
			end
			drain();
		end

		repeat (60) @(posedge clk);
		if (faults == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
